// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/bbct_pkg.sv -----
package bbct_pkg;

   localparam int NUM_BUFFERS_DEFAULT = 16;
   localparam int BLOCK_BITS_DEFAULT  = 32;

   localparam int OPCODE_W    = 3;
   localparam int REQ_BLOCK_W = 32;
   localparam int SLOT_PORT_W = 4;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 8;

   localparam logic [COUNT_W-1:0] REF_MAX = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_GET   = 3'd2,
      OP_PUT   = 3'd3,
      OP_FLUSH = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   // Flags rippled from cell to cell: first tag hit and addressed-slot view.
   typedef struct packed {
      logic seen;
      logic not_valid;
      logic any_sel;
      logic sel_in_use;
   } chain_type;

   // Update command broadcast to every cell during the update cycle.
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   hit;
      logic   have_free;
   } cmd_type;

endpackage

// ----- rtl/core/block_buffer_cache_tags_unit.sv -----
// Tag manager for NUM_BUFFERS disk block buffers: one cell per slot holds the block tag,
// an 8-bit saturating reference count, in-use and data-valid marks, and a shift stack
// holds the free slots (highest slot on top after reset). In a transaction, the accept
// edge latches every cell's tag compare and slot select, and the next cycle
// ripples the first hit and the addressed slot through the row of cells, updates the
// cells and the stack, and loads the response register. The next request is taken in
// the cycle after that, provided the response has been or is being taken. No clearing
// pass is needed after reset.
module block_buffer_cache_tags_unit #(
   parameter int NUM_BUFFERS = bbct_pkg::NUM_BUFFERS_DEFAULT,
   parameter int BLOCK_BITS  = bbct_pkg::BLOCK_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bbct_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [bbct_pkg::REQ_BLOCK_W-1:0]    req_block_number,
   input  logic [bbct_pkg::SLOT_PORT_W-1:0]    req_slot,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bbct_pkg::STATUS_W-1:0]       rsp_status,
   output logic [bbct_pkg::SLOT_PORT_W-1:0]    rsp_slot_out,
   output logic [bbct_pkg::REQ_BLOCK_W-1:0]    rsp_disk_block,
   output logic                                rsp_read_request,
   output logic                                rsp_write_request
);

   localparam int SLOT_W = $clog2(NUM_BUFFERS);
   localparam int SPW    = bbct_pkg::SLOT_PORT_W;
   localparam int DBW    = bbct_pkg::REQ_BLOCK_W;

   typedef enum logic {S_IDLE, S_BUSY} state_type;

   state_type                     state_ff;
   logic                          rsp_valid_ff;
   logic [bbct_pkg::STATUS_W-1:0] status_ff;
   logic [SPW-1:0]                slot_out_ff;
   logic [DBW-1:0]                disk_block_ff;
   logic                          read_ff, write_ff;

   logic [bbct_pkg::OPCODE_W-1:0] opcode_ff;
   logic [BLOCK_BITS-1:0]         block_ff;
   logic [SPW-1:0]                slot_ff;

   logic                  accept;
   logic [BLOCK_BITS-1:0] lookup_block;
   bbct_pkg::cmd_type     cmd;
   logic                  op_known;
   logic                  have_free;
   logic [SLOT_W-1:0]     top_slot;
   logic                  pop, push;

   bbct_pkg::chain_type          chain_w [NUM_BUFFERS+1];
   logic [SLOT_W-1:0]            idx_w   [NUM_BUFFERS+1];
   logic [BLOCK_BITS-1:0]        tag_w   [NUM_BUFFERS+1];
   logic [bbct_pkg::COUNT_W-1:0] count_w [NUM_BUFFERS+1];

   bbct_pkg::chain_type          fin;
   logic [bbct_pkg::COUNT_W-1:0] sel_count;

   bbct_pkg::status_type status_res;
   logic [SPW-1:0]       slot_res;
   logic [DBW-1:0]       dblk_res;
   logic                 read_res, write_res;

   assign req_ready    = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept       = req_valid && req_ready;
   assign lookup_block = BLOCK_BITS'(req_block_number);

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= req_opcode;
         block_ff  <= lookup_block;
         slot_ff   <= req_slot;
      end
   end

   assign chain_w[0] = '0;
   assign idx_w[0]   = '0;
   assign tag_w[0]   = '0;
   assign count_w[0] = '0;

   for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
      bbct_cell #(
         .INDEX      (g),
         .SLOT_W     (SLOT_W),
         .BLOCK_BITS (BLOCK_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .capture       (accept),
         .lookup_block  (lookup_block),
         .lookup_slot   (req_slot),
         .cmd           (cmd),
         .install_block (block_ff),
         .pop_slot      (top_slot),
         .chain_prev    (chain_w[g]),
         .idx_prev      (idx_w[g]),
         .tag_prev      (tag_w[g]),
         .count_prev    (count_w[g]),
         .chain_next    (chain_w[g+1]),
         .idx_next      (idx_w[g+1]),
         .tag_next      (tag_w[g+1]),
         .count_next    (count_w[g+1])
      );
   end

   bbct_stack #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .SLOT_W      (SLOT_W)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .push      (push),
      .push_slot (SLOT_W'(slot_ff)),
      .top_slot  (top_slot),
      .have_free (have_free)
   );

   assign fin       = chain_w[NUM_BUFFERS];
   assign sel_count = count_w[NUM_BUFFERS];
   assign op_known  = (opcode_ff <= bbct_pkg::OP_FLUSH);

   always_comb begin
      cmd.valid     = (state_ff == S_BUSY) && op_known;
      cmd.op        = bbct_pkg::op_type'(opcode_ff);
      cmd.hit       = fin.seen;
      cmd.have_free = have_free;
   end

   assign pop  = cmd.valid && (cmd.op == bbct_pkg::OP_ALLOC) && !fin.seen && have_free;
   // release happens when a free drops an in-use slot's count from one to zero
   assign push = cmd.valid && (cmd.op == bbct_pkg::OP_FREE) && fin.any_sel
                 && fin.sel_in_use && (sel_count == bbct_pkg::COUNT_W'(1));

   always_comb begin
      status_res = bbct_pkg::ST_OK;
      slot_res   = slot_ff;
      dblk_res   = '0;
      read_res   = 1'b0;
      write_res  = 1'b0;
      if (opcode_ff == bbct_pkg::OP_ALLOC) begin
         if (fin.seen) begin
            slot_res = SPW'(idx_w[NUM_BUFFERS]);
            dblk_res = DBW'(block_ff);
            read_res = fin.not_valid;
         end else if (have_free) begin
            slot_res = SPW'(top_slot);
            dblk_res = DBW'(block_ff);
            read_res = 1'b1;
         end else begin
            status_res = bbct_pkg::ST_FULL;
            slot_res   = '0;
         end
      end else if (op_known && fin.any_sel) begin
         case (cmd.op)
            bbct_pkg::OP_FREE, bbct_pkg::OP_PUT: begin
               if (sel_count == '0) status_res = bbct_pkg::ST_ZERO;
            end
            bbct_pkg::OP_GET: begin
               if (!fin.sel_in_use) status_res = bbct_pkg::ST_ZERO;
            end
            bbct_pkg::OP_FLUSH: begin
               if (fin.sel_in_use) begin
                  write_res = 1'b1;
                  dblk_res  = DBW'(tag_w[NUM_BUFFERS]);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) state_ff <= S_BUSY;
            end
            S_BUSY: begin
               state_ff      <= S_IDLE;
               rsp_valid_ff  <= 1'b1;
               status_ff     <= status_res;
               slot_out_ff   <= slot_res;
               disk_block_ff <= dblk_res;
               read_ff       <= read_res;
               write_ff      <= write_res;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_slot_out      = slot_out_ff;
   assign rsp_disk_block    = disk_block_ff;
   assign rsp_read_request  = read_ff;
   assign rsp_write_request = write_ff;

endmodule

// ----- rtl/core/bbct_cell.sv -----
module bbct_cell #(
   parameter int INDEX      = 0,
   parameter int SLOT_W     = 4,
   parameter int BLOCK_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              capture,
   input  logic [BLOCK_BITS-1:0]             lookup_block,
   input  logic [bbct_pkg::SLOT_PORT_W-1:0]  lookup_slot,
   input  bbct_pkg::cmd_type                 cmd,
   input  logic [BLOCK_BITS-1:0]             install_block,
   input  logic [SLOT_W-1:0]                 pop_slot,
   input  bbct_pkg::chain_type               chain_prev,
   input  logic [SLOT_W-1:0]                 idx_prev,
   input  logic [BLOCK_BITS-1:0]             tag_prev,
   input  logic [bbct_pkg::COUNT_W-1:0]      count_prev,
   output bbct_pkg::chain_type               chain_next,
   output logic [SLOT_W-1:0]                 idx_next,
   output logic [BLOCK_BITS-1:0]             tag_next,
   output logic [bbct_pkg::COUNT_W-1:0]      count_next
);

   logic [BLOCK_BITS-1:0]        tag_ff, tag_in;
   logic [bbct_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         in_use_ff, in_use_in;
   logic                         valid_ff, valid_in;
   logic                         match_ff, match_in;
   logic                         sel_ff, sel_in;
   logic                         first;

   assign first = match_ff && !chain_prev.seen;

   always_comb begin
      match_in = match_ff;
      sel_in   = sel_ff;
      if (capture) begin
         match_in = in_use_ff && (tag_ff == lookup_block);
         sel_in   = (int'(lookup_slot) == INDEX);
      end
   end

   always_comb begin
      tag_in    = tag_ff;
      count_in  = count_ff;
      in_use_in = in_use_ff;
      valid_in  = valid_ff;
      if (cmd.valid) begin
         case (cmd.op)
            bbct_pkg::OP_ALLOC: begin
               if (cmd.hit) begin
                  if (first) begin
                     if (count_ff != bbct_pkg::REF_MAX) count_in = count_ff + 1'b1;
                     valid_in = 1'b1;
                  end
               end else if (cmd.have_free && pop_slot == SLOT_W'(INDEX)) begin
                  in_use_in = 1'b1;
                  tag_in    = install_block;
                  count_in  = bbct_pkg::COUNT_W'(1);
                  valid_in  = 1'b1;   // read request goes out with this transaction
               end
            end
            bbct_pkg::OP_FREE: begin
               if (sel_ff && count_ff != '0) begin
                  count_in = count_ff - 1'b1;
                  if (count_ff == bbct_pkg::COUNT_W'(1) && in_use_ff) begin
                     in_use_in = 1'b0;
                     valid_in  = 1'b0;
                  end
               end
            end
            bbct_pkg::OP_GET: begin
               if (sel_ff && in_use_ff && count_ff != bbct_pkg::REF_MAX)
                  count_in = count_ff + 1'b1;
            end
            bbct_pkg::OP_PUT: begin
               if (sel_ff && count_ff != '0) count_in = count_ff - 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      chain_next.seen       = chain_prev.seen | match_ff;
      chain_next.not_valid  = chain_prev.not_valid | (first & ~valid_ff);
      chain_next.any_sel    = chain_prev.any_sel | sel_ff;
      chain_next.sel_in_use = chain_prev.sel_in_use | (sel_ff & in_use_ff);
      idx_next   = idx_prev | (first ? SLOT_W'(INDEX) : '0);
      tag_next   = tag_prev | (sel_ff ? tag_ff : '0);
      count_next = count_prev | (sel_ff ? count_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         in_use_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         count_ff  <= count_in;
         in_use_ff <= in_use_in;
         valid_ff  <= valid_in;
      end
   end

   // tag only matters while in use
   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      match_ff <= match_in;
      sel_ff   <= sel_in;
   end

endmodule

// ----- rtl/core/bbct_stack.sv -----
module bbct_stack #(
   parameter int NUM_BUFFERS = bbct_pkg::NUM_BUFFERS_DEFAULT,
   parameter int SLOT_W      = $clog2(NUM_BUFFERS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop,
   input  logic              push,
   input  logic [SLOT_W-1:0] push_slot,
   output logic [SLOT_W-1:0] top_slot,
   output logic              have_free
);

   localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

   // entry 0 is the top; pop shifts toward it, push shifts away
   logic [SLOT_W-1:0] entry_ff [NUM_BUFFERS];
   logic [SLOT_W-1:0] entry_in [NUM_BUFFERS];
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      for (int i = 0; i < NUM_BUFFERS; i++) entry_in[i] = entry_ff[i];
      count_in = count_ff;
      if (pop) begin
         for (int i = 0; i < NUM_BUFFERS - 1; i++) entry_in[i] = entry_ff[i+1];
         count_in = count_ff - 1'b1;
      end else if (push) begin
         entry_in[0] = push_slot;
         for (int i = 1; i < NUM_BUFFERS; i++) entry_in[i] = entry_ff[i-1];
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) entry_ff[i] <= SLOT_W'(NUM_BUFFERS - 1 - i);
         count_ff <= CNT_W'(NUM_BUFFERS);
      end else begin
         for (int i = 0; i < NUM_BUFFERS; i++) entry_ff[i] <= entry_in[i];
         count_ff <= count_in;
      end
   end

   assign top_slot  = entry_ff[0];
   assign have_free = (count_ff != '0);

endmodule

// ----- rtl/core/bbct_checker.sv -----
`include "assert_macros.svh"

module bbct_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic [bbct_pkg::STATUS_W-1:0]       rsp_status,
   input logic [bbct_pkg::SLOT_PORT_W-1:0]    rsp_slot_out,
   input logic [bbct_pkg::REQ_BLOCK_W-1:0]    rsp_disk_block,
   input logic                                rsp_read_request,
   input logic                                rsp_write_request
);

   // a refused alloc carries nothing else
   `ASSERT_IMPLY(a_full_empty, clock, reset,
      rsp_valid && rsp_status == bbct_pkg::ST_FULL,
      rsp_slot_out == '0 && rsp_disk_block == '0 && !rsp_read_request && !rsp_write_request)

   `ASSERT_IMPLY(a_zero_quiet, clock, reset,
      rsp_valid && rsp_status == bbct_pkg::ST_ZERO,
      rsp_disk_block == '0 && !rsp_read_request && !rsp_write_request)

   // read comes only from a successful alloc, write only from a flush
   `ASSERT_IMPLY(a_rd_wr_excl, clock, reset,
      rsp_valid && (rsp_read_request || rsp_write_request),
      rsp_status == bbct_pkg::ST_OK && !(rsp_read_request && rsp_write_request))

   // one transaction in flight: the update cycle blocks the next request
   `ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_valid && req_ready,
      !req_ready)

endmodule

bind block_buffer_cache_tags_unit bbct_checker u_bbct_checker (.*);

// ----- test/block_buffer_cache_tags_unit_test.sv -----
module block_buffer_cache_tags_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bbct_pkg::*;

   localparam int NUM_SLOTS    = NUM_BUFFERS_DEFAULT;
   localparam int POOL_SIZE    = 8;
   localparam int REPORT_LIMIT = 10;
   localparam int HALF_PERIOD  = 6;
   localparam int WATCHDOG_NS  = 400_000 * 2 * HALF_PERIOD;
   localparam int DRAIN_LIMIT  = 300;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = OP_FLUSH + 1;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = '1;

   typedef struct {
      status_type                 status;
      logic [SLOT_PORT_W-1:0]     slot_out;
      logic [REQ_BLOCK_W-1:0]     disk_block;
      logic                       read_request;
      logic                       write_request;
   } tag_result_type;

   // Tag/refcount model of the buffer cache plus the queue of responses it predicts.
   class buffer_tag_tracker;
      logic [REQ_BLOCK_W-1:0] slot_tag [NUM_SLOTS];
      logic [COUNT_W-1:0]     slot_refs [NUM_SLOTS];
      bit                     slot_busy [NUM_SLOTS];
      bit                     slot_loaded [NUM_SLOTS];
      int                     spare_stack [NUM_SLOTS];
      int                     spare_count;
      int                     last_slot;
      int                     mismatches;
      tag_result_type         predicted_q [$];

      function new();
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_tag[i]    = '0;
            slot_refs[i]   = '0;
            slot_busy[i]   = 1'b0;
            slot_loaded[i] = 1'b0;
            spare_stack[i] = i;
         end
         spare_count = NUM_SLOTS;
         last_slot   = 0;
         mismatches  = 0;
      endfunction

      function int pending();
         return predicted_q.size();
      endfunction

      // Mostly a slot in use, so that free/get/put/flush do real work.
      function logic [SLOT_PORT_W-1:0] pick_slot();
         int busy_q [$];
         for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_busy[i]) busy_q.push_back(i);
         if (busy_q.size() != 0 && $urandom_range(99) < 80)
            return busy_q[$urandom_range(busy_q.size() - 1)];
         return $urandom_range(NUM_SLOTS - 1);
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [REQ_BLOCK_W-1:0] blk,
                                 logic [SLOT_PORT_W-1:0] slot);
         tag_result_type r;
         int             k;
         bit             hit;
         r.status        = ST_OK;
         r.slot_out      = slot;
         r.disk_block    = '0;
         r.read_request  = 1'b0;
         r.write_request = 1'b0;
         k   = 0;
         hit = 1'b0;
         case (op)
            OP_ALLOC: begin
               // lowest in-use slot with a matching tag wins
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (!hit && slot_busy[i] && slot_tag[i] == blk) begin
                     hit = 1'b1;
                     k   = i;
                  end
               if (hit) begin
                  if (slot_refs[k] != REF_MAX) slot_refs[k]++;
               end else if (spare_count == 0) begin
                  r.status   = ST_FULL;
                  r.slot_out = '0;
               end else begin
                  spare_count--;
                  k = spare_stack[spare_count];
                  slot_busy[k]   = 1'b1;
                  slot_tag[k]    = blk;
                  slot_refs[k]   = 1;
                  slot_loaded[k] = 1'b0;
               end
               if (r.status == ST_OK) begin
                  r.slot_out   = k[SLOT_PORT_W-1:0];
                  r.disk_block = slot_tag[k];
                  if (!slot_loaded[k]) begin
                     r.read_request = 1'b1;
                     slot_loaded[k] = 1'b1;
                  end
               end
            end
            OP_FREE: begin
               if (slot_refs[slot] == 0) begin
                  r.status = ST_ZERO;
               end else begin
                  slot_refs[slot]--;
                  if (slot_refs[slot] == 0 && slot_busy[slot]) begin
                     slot_busy[slot]   = 1'b0;
                     slot_tag[slot]    = '0;
                     slot_loaded[slot] = 1'b0;
                     if (spare_count < NUM_SLOTS) begin
                        spare_stack[spare_count] = slot;
                        spare_count++;
                     end
                  end
               end
            end
            OP_GET: begin
               if (!slot_busy[slot]) r.status = ST_ZERO;
               else if (slot_refs[slot] != REF_MAX) slot_refs[slot]++;
            end
            OP_PUT: begin
               if (slot_refs[slot] == 0) r.status = ST_ZERO;
               else slot_refs[slot]--;
            end
            OP_FLUSH: begin
               if (slot_busy[slot]) begin
                  r.write_request = 1'b1;
                  r.disk_block    = slot_tag[slot];
               end
            end
            default: ;
         endcase
         last_slot = r.slot_out;
         predicted_q.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [SLOT_PORT_W-1:0] slot,
                                   logic [REQ_BLOCK_W-1:0] blk, logic rd, logic wr);
         tag_result_type e;
         if (predicted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected response status %0d slot %0d block %h rd %b wr %b",
                        $time, status, slot, blk, rd, wr);
            return;
         end
         e = predicted_q.pop_front();
         if (status !== e.status || slot !== e.slot_out || blk !== e.disk_block ||
             rd !== e.read_request || wr !== e.write_request) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $write("%0t: mismatch expected status %0d slot %0d block %h rd %b wr %b,",
                      $time, e.status, e.slot_out, e.disk_block, e.read_request,
                      e.write_request);
               $display(" got status %0d slot %0d block %h rd %b wr %b",
                        status, slot, blk, rd, wr);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [REQ_BLOCK_W-1:0] req_block_number;
   logic [SLOT_PORT_W-1:0] req_slot;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STATUS_W-1:0]    rsp_status;
   logic [SLOT_PORT_W-1:0] rsp_slot_out;
   logic [REQ_BLOCK_W-1:0] rsp_disk_block;
   logic                   rsp_read_request;
   logic                   rsp_write_request;

   buffer_tag_tracker      tracker;
   logic [REQ_BLOCK_W-1:0] block_pool [POOL_SIZE];
   int                     send_idle_pct;
   int                     recv_idle_pct;
   int                     hold_cycles;
   int                     items_sent;

   block_buffer_cache_tags_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_block_number  (req_block_number),
      .req_slot          (req_slot),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_disk_block    (rsp_disk_block),
      .rsp_read_request  (rsp_read_request),
      .rsp_write_request (rsp_write_request)
   );

   always #HALF_PERIOD clock = ~clock;

   // Response side: random back-pressure, or a long hold-off when requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_status, rsp_slot_out, rsp_disk_block,
                                   rsp_read_request, rsp_write_request);
         if (req_valid && req_ready)
            tracker.note_request(req_opcode, req_block_number, req_slot);
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is accepted.
   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [REQ_BLOCK_W-1:0] blk,
                               input logic [SLOT_PORT_W-1:0] slot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_block_number <= blk;
      req_slot         <= slot;
      do @(posedge clock); while (!req_ready);
      if (op <= OP_FLUSH) items_sent++;
      @(negedge clock);
   endtask

   task automatic fill_cache();
      repeat (NUM_SLOTS + 2) send_request(OP_ALLOC, $urandom, $urandom_range(NUM_SLOTS - 1));
   endtask

   // Release every slot; a busy slot at count zero needs a get before it can be freed.
   task automatic drain_cache();
      int n;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         n = 0;
         while (tracker.slot_busy[i] && n < DRAIN_LIMIT) begin
            if (tracker.slot_refs[i] == 0) send_request(OP_GET, $urandom, i);
            else send_request(OP_FREE, $urandom, i);
            n++;
         end
      end
   endtask

   task automatic saturate_counter();
      logic [REQ_BLOCK_W-1:0] blk;
      logic [SLOT_PORT_W-1:0] s;
      drain_cache();
      blk = $urandom;
      send_request(OP_ALLOC, blk, $urandom_range(NUM_SLOTS - 1));
      s = tracker.last_slot;
      repeat (int'(REF_MAX) + 1) send_request(OP_GET, blk, s);
      send_request(OP_ALLOC, blk, s);
      repeat (int'(REF_MAX) + 1) send_request(OP_PUT, blk, s);
      send_request(OP_FREE, blk, s);
      send_request(OP_GET, blk, s);
      send_request(OP_FREE, blk, s);
   endtask

   task automatic run_directed();
      send_request(OP_GET, '0, 0);
      send_request(OP_PUT, '1, NUM_SLOTS - 1);
      send_request(OP_FREE, '0, 7);
      send_request(OP_FLUSH, '0, 3);
      send_request(OP_ALLOC, '0, 0);
      send_request(OP_ALLOC, '1, 0);
      send_request(OP_ALLOC, '0, 5);
      send_request(OP_GET, '0, NUM_SLOTS - 1);
      send_request(OP_PUT, '0, NUM_SLOTS - 1);
      send_request(OP_FLUSH, '0, NUM_SLOTS - 1);
      send_request(OP_FLUSH, '0, NUM_SLOTS - 2);
      send_request(OP_FREE, '0, NUM_SLOTS - 2);
      send_request(OP_FREE, '0, NUM_SLOTS - 2);
      send_request(OP_ALLOC, 32'h8000_0001, 0);
      send_request(OP_SPARE_LO, '1, NUM_SLOTS - 1);
      send_request(OP_SPARE_LO + 1, 32'h5555_AAAA, 0);
      send_request(OP_SPARE_HI, '0, NUM_SLOTS - 1);
      send_request(OP_FREE, '0, NUM_SLOTS - 1);
      send_request(OP_FREE, '0, NUM_SLOTS - 1);
      send_request(OP_ALLOC, 32'h1234_5678, 0);
      send_request(OP_PUT, '0, tracker.last_slot);
      send_request(OP_FREE, '0, tracker.last_slot);
      send_request(OP_GET, '0, tracker.last_slot);
      send_request(OP_FREE, '0, tracker.last_slot);
   endtask

   task automatic random_item();
      int                     pick;
      logic [REQ_BLOCK_W-1:0] blk;
      pick = $urandom_range(999);
      blk  = ($urandom_range(99) < 70) ? block_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      if (pick < 15)
         fill_cache();
      else if (pick < 25)
         drain_cache();
      else if (pick < 400)
         send_request(OP_ALLOC, blk, $urandom_range(NUM_SLOTS - 1));
      else if (pick < 580)
         send_request(OP_FREE, $urandom, tracker.pick_slot());
      else if (pick < 680)
         send_request(OP_GET, $urandom, tracker.pick_slot());
      else if (pick < 780)
         send_request(OP_PUT, $urandom, tracker.pick_slot());
      else if (pick < 900)
         send_request(OP_FLUSH, $urandom, tracker.pick_slot());
      else
         send_request($urandom_range(OP_SPARE_HI, OP_SPARE_LO), $urandom,
                      $urandom_range(NUM_SLOTS - 1));
   endtask

   task automatic run_random(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) random_item();
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_ALLOC;
      req_block_number = '0;
      req_slot         = '0;
      rsp_ready        = 1'b0;
      send_idle_pct    = 30;
      recv_idle_pct    = 57;
      hold_cycles      = 0;
      items_sent       = 0;
      tracker          = new();
      block_pool[0]    = '0;
      block_pool[1]    = '1;
      block_pool[2]    = 32'h8000_0000;
      block_pool[3]    = 32'h0000_0001;
      for (int i = 4; i < POOL_SIZE; i++) block_pool[i] = $urandom;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(150);

      send_idle_pct = 57;
      recv_idle_pct = 30;
      run_random(150);

      // no idling; the long hold-off backs up the response path and stalls requests
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 200;
      saturate_counter();
      run_random(150);
      req_valid <= 1'b0;

      for (int c = 0; c < 20_000 && tracker.pending() != 0; c++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("block_buffer_cache_tags_unit verification clean");
      else
         $display("block_buffer_cache_tags_unit verification failed");
      $finish;
   end

   initial begin
      #(WATCHDOG_NS);
      $display("block_buffer_cache_tags_unit verification failed");
      $finish;
   end

endmodule
